>>> hw/rtl/oaht_pkg.sv
package oaht_pkg;

  localparam int SLOTS = 1024;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SIZE_W = $clog2(SLOTS + 1);
  localparam int KEY_W = 32;
  localparam int MOD_CNT_W = $clog2(KEY_W + 1);
  localparam int SLOT_FIELD_W = 10;
  localparam int COUNT_W = 11;
  localparam int CFG_SIZE_W = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 1'd1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MOD,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic mod_step;
    logic rd;
    logic advance;
    logic finish_hit;
    logic finish_miss;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mod_done;
    logic hit;
    logic last_probe;
  } status_t;

endpackage

>>> hw/rtl/oaht_if.sv
interface oaht_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [31:0] key;
  modport source (output valid, output opcode, output key, input ready);
  modport sink (input valid, input opcode, input key, output ready);
endinterface

interface oaht_out_if;
  logic valid;
  logic ready;
  logic [9:0] slot;
  logic success;
  logic [10:0] probe_count;
  modport source (output valid, output slot, output success, output probe_count, input ready);
  modport sink (input valid, input slot, input success, input probe_count, output ready);
endinterface

interface oaht_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/oaht_ram.sv
module oaht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/oaht_ctrl.sv
module oaht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  oaht_pkg::status_t status,
  output oaht_pkg::cmd_t    cmd
);
  import oaht_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MOD;
      ST_CLEAR: if (status.clear_last) state_next = ST_IDLE;
      ST_MOD:   if (status.mod_done) state_next = ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: if (status.hit || status.last_probe) state_next = ST_DONE;
                else state_next = ST_READ;
      ST_DONE:  if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_MOD:   cmd.mod_step = 1'b1;
      ST_READ:  cmd.rd = 1'b1;
      ST_CHECK: begin
        if (status.hit) begin
          cmd.finish_hit = 1'b1;
        end else if (status.last_probe) begin
          cmd.finish_miss = 1'b1;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_DONE:  out_valid = 1'b1;
      default:  ;
    endcase
  end

endmodule

>>> hw/rtl/oaht_dp.sv
module oaht_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  oaht_pkg::cmd_t                      cmd,
  output oaht_pkg::status_t                   status,
  input  logic                                in_opcode,
  input  logic [oaht_pkg::KEY_W-1:0]          in_key,
  input  logic [oaht_pkg::SIZE_W-1:0]         size,
  input  logic                                quad,
  output logic [oaht_pkg::SLOT_FIELD_W-1:0]   res_slot,
  output logic                                res_success,
  output logic [oaht_pkg::COUNT_W-1:0]        res_count
);
  import oaht_pkg::*;

  logic             op;
  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] quot;
  logic [SIZE_W-1:0] rem;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [SLOT_W-1:0] pos;
  logic [SIZE_W-1:0] idx;
  logic [SLOT_W-1:0] clr_addr;
  logic              rd_q;
  logic [KEY_W-1:0]  rd_key;
  logic              rd_used;
  logic              used_we;
  logic [SLOT_W-1:0] used_addr;
  logic              used_wdata;
  logic [SIZE_W:0]   rem_shift;
  logic [SIZE_W+1:0] pos_sum;
  logic [SIZE_W+1:0] pos_wrap;
  logic [SIZE_W:0]   step_next;

  // restoring division, one quotient bit a cycle
  assign rem_shift = {rem, quot[KEY_W-1]};

  // offset to the next probe: linear 1, quadratic (i+1)^2-i^2 = 2i+1, reduced below size
  always_comb begin
    logic [SIZE_W+1:0] s;
    s = quad ? {1'b0, idx, 1'b1} : {{(SIZE_W+1){1'b0}}, 1'b1};
    if (s >= {1'b0, size, 1'b0}) s = s - {1'b0, size, 1'b0};
    if (s >= {2'b0, size}) s = s - {2'b0, size};
    step_next = s[SIZE_W:0];
  end

  assign pos_sum = {{(SIZE_W-SLOT_W+2){1'b0}}, pos} + {1'b0, step_next};
  assign pos_wrap = (pos_sum >= {2'b0, size}) ? pos_sum - {2'b0, size}
                                             : pos_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
    if (cmd.load) begin
      op <= in_opcode;
      key <= in_key;
      quot <= in_key;
      rem <= '0;
      mod_cnt <= '0;
    end
    if (cmd.mod_step) begin
      mod_cnt <= mod_cnt + 1'b1;
      quot <= {quot[KEY_W-2:0], 1'b0};
      if (rem_shift >= {1'b0, size}) rem <= SIZE_W'(rem_shift - {1'b0, size});
      else rem <= rem_shift[SIZE_W-1:0];
      idx <= '0;
      if (status.mod_done) begin
        pos <= (rem_shift >= {1'b0, size}) ?
               SLOT_W'(rem_shift - {1'b0, size}) : SLOT_W'(rem_shift);
      end
    end
    if (cmd.advance) begin
      idx <= idx + 1'b1;
      pos <= pos_wrap[SLOT_W-1:0];
    end
    rd_q <= cmd.rd;
    if (cmd.finish_hit) begin
      res_slot <= SLOT_FIELD_W'(pos);
      res_success <= 1'b1;
      res_count <= COUNT_W'(idx);
    end else if (cmd.finish_miss) begin
      res_slot <= '0;
      res_success <= 1'b0;
      res_count <= COUNT_W'(size);
    end
  end

  assign used_we = cmd.clear_step || (cmd.finish_hit && op == OP_INSERT);
  assign used_addr = cmd.clear_step ? clr_addr : pos;
  assign used_wdata = !cmd.clear_step;

  oaht_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used (
    .clk(clk), .we(used_we), .waddr(used_addr), .wdata(used_wdata),
    .re(cmd.rd), .raddr(pos), .rdata(rd_used)
  );

  oaht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_keys (
    .clk(clk), .we(cmd.finish_hit && op == OP_INSERT), .waddr(pos), .wdata(key),
    .re(cmd.rd), .raddr(pos), .rdata(rd_key)
  );

  always_comb begin
    status.clear_last = (clr_addr == SLOT_W'(SLOTS - 1));
    status.mod_done = (mod_cnt == MOD_CNT_W'(KEY_W - 1));
    status.hit = rd_q && ((op == OP_INSERT) ? !rd_used : (rd_used && rd_key == key));
    status.last_probe = (idx == size - 1'b1);
  end

endmodule

>>> hw/rtl/open_addressing_hash_table.sv
// channel  dir  fields
// in       in   opcode, key
// out      out  slot, success, probe_count
// cfg      in   index (0 table_size, 1 probe_mode), data
// after reset a clearing pass over all 1024 slots runs; no item is taken meanwhile
// an item first runs the bit-serial divider for the home-slot remainder, then
// probes the table (registered ram read, then compare), up to size probes;
// the result is then held until taken, and the block passes through idle before
// the next item is taken; the block holds one item at a time
// a stalled result holds the block; config writes are always taken
module open_addressing_hash_table (
  input logic clk,
  input logic rst,
  oaht_in_if.sink   in_ch,
  oaht_out_if.source out_ch,
  oaht_cfg_if.sink  cfg
);
  import oaht_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic [CFG_SIZE_W-1:0] table_size;
  logic                  probe_mode;
  logic [SIZE_W-1:0]     size;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= CFG_SIZE_W'(SLOTS);
      probe_mode <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TABLE_SIZE: table_size <= cfg.data[CFG_SIZE_W-1:0];
        REG_PROBE_MODE: probe_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (table_size == '0) size = SIZE_W'(1);
    else if (32'(table_size) > SLOTS) size = SIZE_W'(SLOTS);
    else size = SIZE_W'(table_size);
  end

  oaht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(status), .cmd(cmd)
  );

  oaht_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_opcode(in_ch.opcode), .in_key(in_ch.key), .size(size), .quad(probe_mode),
    .res_slot(out_ch.slot), .res_success(out_ch.success), .res_count(out_ch.probe_count)
  );

endmodule

>>> bench/tb_open_addressing_hash_table.sv
module tb_open_addressing_hash_table;
  import oaht_pkg::*;

  typedef struct packed {
    logic [9:0] slot;
    logic success;
    logic [10:0] probe_count;
  } lookup_t;

  logic clk;
  logic rst;
  bit failed;
  bit calm;

  oaht_in_if in_ch();
  oaht_out_if out_ch();
  oaht_cfg_if cfg();

  open_addressing_hash_table uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  // shadow of the table
  logic [31:0] shadow_keys [SLOTS];
  bit shadow_used [SLOTS];
  int unsigned size_reg;
  bit quad_mode;
  lookup_t pending_results[$];
  logic [31:0] inserted_keys[$];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("FAIL");
    $finish;
  end

  function automatic lookup_t hash_lookup(logic op, logic [31:0] key);
    int unsigned sz;
    int unsigned home;
    int unsigned p;
    lookup_t r;
    sz = (size_reg == 0) ? 1 : (size_reg > SLOTS ? SLOTS : size_reg);
    home = key % sz;
    for (int unsigned i = 0; i < sz; i++) begin
      longint unsigned step;
      step = quad_mode ? longint'(i) * i : i;
      p = 32'((home + step) % sz);
      if (op == OP_INSERT ? !shadow_used[p] : (shadow_used[p] && shadow_keys[p] == key)) begin
        if (op == OP_INSERT) begin
          shadow_used[p] = 1;
          shadow_keys[p] = key;
        end
        r.slot = p[9:0];
        r.success = 1;
        r.probe_count = i[10:0];
        return r;
      end
    end
    r.slot = 0;
    r.success = 0;
    r.probe_count = sz[10:0];
    return r;
  endfunction

  task automatic send_item(logic op, logic [31:0] key);
    while (!calm && $urandom_range(99) < 16) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.key <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(hash_lookup(op, key));
    if (op == OP_INSERT) inserted_keys.push_back(key);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [10:0] val);
    drain();
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
    if (idx == REG_TABLE_SIZE) size_reg = val;
    else quad_mode = val[0];
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        lookup_t want;
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result slot=%0d", $time, out_ch.slot);
          failed = 1;
        end else begin
          want = pending_results.pop_front();
          if (want.slot !== out_ch.slot || want.success !== out_ch.success ||
              want.probe_count !== out_ch.probe_count) begin
            $display("%0t mismatch expected slot=%0d ok=%0d probes=%0d",
                     $time, want.slot, want.success, want.probe_count);
            $display("%0t   got slot=%0d ok=%0d probes=%0d",
                     $time, out_ch.slot, out_ch.success, out_ch.probe_count);
            failed = 1;
          end
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  task automatic test_extremes();
    send_item(OP_FIND, 32'h0);
    send_item(OP_INSERT, 32'h0);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0);
    send_item(OP_FIND, 32'hFFFF_FFFF);
    send_item(OP_FIND, 32'h0);
    send_item(OP_FIND, 32'h1234_5678);
    send_item(OP_INSERT, 32'hAAAA_5555);
    send_item(OP_INSERT, 32'h5555_AAAA);
    send_item(OP_FIND, 32'h5555_AAAA);
  endtask

  task automatic test_full_tiny();
    // size 0 acts as 1, then fill a size-4 table and overflow
    write_reg(REG_TABLE_SIZE, 11'd0);
    send_item(OP_FIND, 32'd7);
    send_item(OP_INSERT, 32'd9);
    send_item(OP_INSERT, 32'd3);
    write_reg(REG_TABLE_SIZE, 11'd4);
    write_reg(REG_PROBE_MODE, 11'd1);
    for (int i = 0; i < 5; i++) send_item(OP_INSERT, 32'(8 * i));
    send_item(OP_FIND, 32'd16);
    send_item(OP_FIND, 32'd99);
  endtask

  task automatic test_random_phase(int unsigned sz, bit quad, int n);
    write_reg(REG_TABLE_SIZE, sz[10:0]);
    write_reg(REG_PROBE_MODE, {10'd0, quad});
    for (int i = 0; i < n; i++) begin
      logic [31:0] k;
      logic op;
      op = 1'($urandom_range(1));
      case ($urandom_range(3))
        0: k = $urandom;
        1: k = $urandom_range(63);
        default: k = inserted_keys.size() ? inserted_keys[$urandom_range(inserted_keys.size()-1)]
                                          : $urandom;
      endcase
      send_item(op, k);
    end
  endtask

  initial begin
    rst = 1;
    in_ch.valid = 0; in_ch.opcode = 0; in_ch.key = 0;
    out_ch.ready = 0;
    cfg.valid = 0; cfg.index = 0; cfg.data = 0;
    size_reg = 1024;
    quad_mode = 0;
    calm = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    test_extremes();
    test_full_tiny();
    test_random_phase(7, 0, 60);
    test_random_phase(16, 1, 80);
    drain();
    calm = 1;
    test_random_phase(2, 0, 40);
    calm = 0;
    test_random_phase(1, 1, 30);
    test_random_phase(33, 1, 90);
    test_random_phase(12, 0, 90);
    test_random_phase(2047, 0, 40);
    test_random_phase(1024, 1, 40);
    test_random_phase(40, 0, 50);
    drain();
    repeat (2500) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
